// ===== hw/rtl/sha1s_pkg.sv =====
package sha1s_pkg;

    // Input request: command plus message byte
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_req;

    // Output request: one digest byte
    typedef struct packed {
        logic [7:0] digest_byte;
        logic       last_byte;
    } t_out_rsp;

    // Queue head as seen by the back end, already classified
    typedef struct packed {
        logic       valid;
        logic       is_finish;
        logic [7:0] data_byte;
    } t_queue_head;

    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [4:0] LAST_DIGEST_BYTE = 5'd19;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    // Round function selected by round number
    function automatic logic [31:0] round_f(input logic [6:0] round,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] res;
        if (round < 7'd20) begin
            res = (b & c) | (~b & d);
        end else if (round < 7'd40) begin
            res = b ^ c ^ d;
        end else if (round < 7'd60) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    // Round constant selected by round number
    function automatic logic [31:0] round_k(input logic [6:0] round);
        logic [31:0] res;
        if (round < 7'd20) begin
            res = K_0;
        end else if (round < 7'd40) begin
            res = K_1;
        end else if (round < 7'd60) begin
            res = K_2;
        end else begin
            res = K_3;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/sha1s_front.sv =====
module sha1s_front #(
    parameter int QUEUE_DEPTH = sha1s_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha1s_pkg::t_in_req    i_in_req,
    input  logic                  i_pop,
    output sha1s_pkg::t_queue_head o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sha1s_pkg::t_in_req r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic push;
    logic pop;

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_count != '0);

    // Classify the head request for the back end
    assign o_head.valid     = (r_count != '0);
    assign o_head.is_finish = (r_entry[r_rd_ptr].command == sha1s_pkg::CMD_FINISH);
    assign o_head.data_byte = r_entry[r_rd_ptr].data_byte;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_in_req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sha1s_back.sv =====
module sha1s_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1s_pkg::t_queue_head i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output sha1s_pkg::t_out_rsp    o_out_rsp
);

    localparam logic [2:0] S_ABSORB = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_LEN    = 3'd2;
    localparam logic [2:0] S_COMP   = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]  r_state;
    logic [2:0]  r_ret;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [63:0] r_len;
    logic        r_pad_first;
    logic [23:0] r_acc;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic [4:0]  r_oidx;
    logic        r_out_valid;
    sha1s_pkg::t_out_rsp r_out;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [2:0]  wr_ret;
    logic        load_out;
    logic [31:0] new_w;
    logic [31:0] t_sum;
    logic [31:0] out_word;
    logic [7:0]  out_byte;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign load_out    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Byte write into the block: absorbed data, padding or length
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = i_head.data_byte;
        wr_ret  = S_ABSORB;
        o_pop   = 1'b0;
        unique case (r_state)
            S_ABSORB: begin
                o_pop = i_head.valid;
                wr_en = i_head.valid && !i_head.is_finish;
            end
            S_PAD: begin
                wr_en   = r_pad_first || (r_fill != sha1s_pkg::LEN_START);
                wr_byte = r_pad_first ? sha1s_pkg::PAD_BYTE : 8'h00;
                wr_ret  = S_PAD;
            end
            S_LEN: begin
                wr_en   = 1'b1;
                wr_byte = r_len[63:56];
                wr_ret  = S_OUT;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Round datapath
    assign new_w = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                 | {31'd0, r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign t_sum = {r_a[26:0], r_a[31:27]} + sha1s_pkg::round_f(r_round, r_b, r_c, r_d)
                 + r_e + sha1s_pkg::round_k(r_round) + r_w[0];

    // Digest byte selection, most significant byte first
    assign out_word = r_h[r_oidx[4:2]];
    always_comb begin
        case (r_oidx[1:0])
            2'd0:    out_byte = out_word[31:24];
            2'd1:    out_byte = out_word[23:16];
            2'd2:    out_byte = out_word[15:8];
            default: out_byte = out_word[7:0];
        endcase
    end

    // Message schedule window, word packing and round registers
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_fill[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= {r_acc, wr_byte};
            end else begin
                r_acc <= {r_acc[15:0], wr_byte};
            end
            if (r_fill == 6'd63) begin
                r_a <= r_h[0];
                r_b <= r_h[1];
                r_c <= r_h[2];
                r_d <= r_h[3];
                r_e <= r_h[4];
            end
        end else if (r_state == S_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= new_w;
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (r_state == S_ABSORB && i_head.valid && i_head.is_finish) begin
            r_len <= {r_count, 3'b000};
        end else if (r_state == S_LEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
        if (load_out) begin
            r_out.digest_byte <= out_byte;
            r_out.last_byte   <= (r_oidx == sha1s_pkg::LAST_DIGEST_BYTE);
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ABSORB;
            r_ret       <= S_ABSORB;
            r_fill      <= '0;
            r_count     <= '0;
            r_pad_first <= 1'b0;
            r_round     <= '0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1s_pkg::H_INIT[i];
            end
        end else begin
            if (r_out_valid && i_out_ready && !load_out) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_fill <= r_fill + 1'b1;
                if (r_state == S_PAD) begin
                    r_pad_first <= 1'b0;
                end
                if (r_fill == 6'd63) begin
                    r_state <= S_COMP;
                    r_ret   <= wr_ret;
                    r_round <= '0;
                end
            end
            unique case (r_state)
                S_ABSORB: begin
                    if (i_head.valid) begin
                        if (i_head.is_finish) begin
                            r_state     <= S_PAD;
                            r_pad_first <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_PAD: begin
                    if (!wr_en) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                end
                S_COMP: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == sha1s_pkg::LAST_ROUND) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_state <= r_ret;
                    r_oidx  <= '0;
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_oidx      <= r_oidx + 1'b1;
                        if (r_oidx == sha1s_pkg::LAST_DIGEST_BYTE) begin
                            // Digest done: restart for the next message
                            r_state <= S_ABSORB;
                            r_count <= '0;
                            r_fill  <= '0;
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= sha1s_pkg::H_INIT[i];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_ABSORB;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/sha1_stream_hasher.sv =====
// SHA-1 hasher fed one request per byte.
// Input channel (i_in_valid / o_in_ready / i_in_req): command 0 absorbs
// data_byte, command 1 finishes the message. Requests land in a short
// queue (QUEUE_DEPTH entries) that decouples the input from the engine.
// Output channel (o_out_valid / i_out_ready / o_out_rsp): after a finish,
// 20 digest bytes, word 0 most significant byte first, last_byte on the
// twentieth.
// Every 64th absorbed byte starts a compression (80 rounds on one shared
// round unit, then the chaining-word add); the engine takes no byte from
// the queue while it runs.
// Finish: 0x80 pad byte, zero padding, 64-bit bit length, one or two
// compressions, then one digest byte per cycle while the receiver is ready.
// Reset (synchronous, active low) empties the queue and loads the initial
// chaining words; after each digest the engine reloads them, the queue is kept.
// When the receiver stalls, the output register holds its byte and the
// engine waits; the queue keeps accepting until it is full.
module sha1_stream_hasher #(
    parameter int QUEUE_DEPTH = sha1s_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sha1s_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sha1s_pkg::t_out_rsp o_out_rsp
);

    sha1s_pkg::t_queue_head head;
    logic                   pop;

    // Front end: request queue and classification
    sha1s_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_pop      (pop),
        .o_head     (head)
    );

    // Back end: block packing, padding, compression and digest output
    sha1s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
